// ----- design/assert_macros.svh -----
// Assertion macros shared by the parser RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/asip_pkg.sv -----
// Shared types and constants of the ASCII signed integer parser.
// No dependencies.
`default_nettype none

package asip_pkg;

    localparam int VALUE_BITS  = 128;
    localparam int OFFSET_BITS = 16;
    localparam int OUT_BITS    = 128;
    localparam int BASE_W      = 6;
    localparam int DIGIT_W     = 7;
    localparam int FIFO_AW     = 1;
    localparam int FIFO_DEPTH  = 1 << FIFO_AW;

    localparam logic [BASE_W-1:0]  MAX_BASE  = BASE_W'(36);
    localparam logic [BASE_W-1:0]  MIN_BASE  = BASE_W'(2);
    localparam logic [DIGIT_W-1:0] NOT_DIGIT = DIGIT_W'(127);

    typedef enum logic [2:0] {
        PH_DONE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef enum logic [2:0] {
        CL_OTHER,
        CL_SPACE,
        CL_PLUS,
        CL_MINUS,
        CL_ZERO,
        CL_X,
        CL_B
    } class_t;

    // Classified character passed from front to back.
    typedef struct packed {
        logic               start;
        class_t             cls;
        logic [DIGIT_W-1:0] digit;
    } tok_t;

endpackage

`default_nettype wire

// ----- design/ascii_signed_integer_parser.sv -----
// ASCII signed integer parser, bases 2 to 36 with prefix detection: top level.
// Usage: s_ch/s_start_req take one character per request; s_start_req marks the
// first character of a string. m_value_high/m_value_low carry the signed 128-bit
// value, m_end_offset the characters consumed, m_saturated an overflow clamp.
// At most one result per string, delivered on the first non-digit or on overflow;
// characters after that are dropped until the next start.
// number_base (APB offset 0) is sampled at each start; 0, 1 or above 36 selects
// auto-detection. Write it only while the parser is idle.
// m_valid is registered; it rises as the back end pops the ending token.
// Throughput: one character per cycle while s_ready is high, set by the
// combinational multiply-by-base and add of the accumulator in the back end.
// A two-entry token queue separates classification from accumulation; while a
// result is held and m_ready is low, the queue fills and s_ready drops.
// Reset (aresetn low, synchronous) clears the queue, the result valid and
// number_base; the parser then ignores characters until a start request.
// Depends on asip_pkg, asip_front, asip_fifo and asip_back.
`default_nettype none

module ascii_signed_integer_parser (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_ch,
    input  wire logic                           s_start_req,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [63:0]                  m_value_high,
    output logic [63:0]                         m_value_low,
    output logic [asip_pkg::OFFSET_BITS-1:0]    m_end_offset,
    output logic                                m_saturated
);
    import asip_pkg::*;

    localparam logic REG_NUMBER_BASE = 1'b0;

    logic [BASE_W-1:0] base_cfg_reg, base_cfg_next;
    logic              wr_en;
    logic              fifo_full, fifo_empty, push, pop;
    tok_t              push_tok, pop_tok;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_NUMBER_BASE);

    always_comb begin
        base_cfg_next = base_cfg_reg;
        if (wr_en) begin
            base_cfg_next = pwdata[BASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_cfg_reg <= '0;
        end else begin
            base_cfg_reg <= base_cfg_next;
        end
    end

    assign prdata = (paddr[2] == REG_NUMBER_BASE) ? 32'(base_cfg_reg) : 32'h0;

    asip_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .s_start_req (s_start_req),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_tok    (push_tok)
    );

    asip_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_tok (push_tok),
        .full     (fifo_full),
        .pop      (pop),
        .pop_tok  (pop_tok),
        .empty    (fifo_empty)
    );

    asip_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_base     (base_cfg_reg),
        .empty        (fifo_empty),
        .tok          (pop_tok),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value_high (m_value_high),
        .m_value_low  (m_value_low),
        .m_end_offset (m_end_offset),
        .m_saturated  (m_saturated)
    );

endmodule

`default_nettype wire

// ----- design/asip_front.sv -----
// Front end: accepts character requests and classifies them into tokens.
// Depends on asip_pkg.
`default_nettype none

module asip_front (
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_ch,
    input  wire logic           s_start_req,
    input  wire logic           fifo_full,
    output logic                push,
    output asip_pkg::tok_t      push_tok
);
    import asip_pkg::*;

    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_PLUS = 8'h2b;
    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UB   = 8'h42;
    localparam logic [7:0] CH_UX   = 8'h58;
    localparam logic [7:0] CH_UZ   = 8'h5a;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LB   = 8'h62;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_LZ   = 8'h7a;

    class_t             cls;
    logic [DIGIT_W-1:0] digit;
    logic [7:0]         diff;

    assign s_ready = !fifo_full;
    assign push    = s_valid && !fifo_full;

    always_comb begin
        unique case (s_ch) inside
            [CH_TAB:CH_CR], CH_SP: cls = CL_SPACE;
            CH_PLUS:               cls = CL_PLUS;
            CH_DASH:               cls = CL_MINUS;
            CH_0:                  cls = CL_ZERO;
            CH_LX, CH_UX:          cls = CL_X;
            CH_LB, CH_UB:          cls = CL_B;
            default:               cls = CL_OTHER;
        endcase
    end

    always_comb begin
        diff  = 8'h00;
        digit = NOT_DIGIT;
        if (s_ch >= CH_0 && s_ch <= CH_9) begin
            diff  = s_ch - CH_0;
            digit = diff[DIGIT_W-1:0];
        end else if (s_ch >= CH_LA && s_ch <= CH_LZ) begin
            diff  = s_ch - CH_LA + 8'd10;
            digit = diff[DIGIT_W-1:0];
        end else if (s_ch >= CH_UA && s_ch <= CH_UZ) begin
            diff  = s_ch - CH_UA + 8'd10;
            digit = diff[DIGIT_W-1:0];
        end
    end

    assign push_tok = '{start: s_start_req, cls: cls, digit: digit};

endmodule

`default_nettype wire

// ----- design/asip_fifo.sv -----
// Short token queue between the parser front and back ends.
// Depends on asip_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module asip_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire asip_pkg::tok_t push_tok,
    output logic                full,
    input  wire logic           pop,
    output asip_pkg::tok_t      pop_tok,
    output logic                empty
);
    import asip_pkg::*;

    tok_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_tok = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

    `ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "token queue popped while empty")
    `ASSERT_ALWAYS(a_no_overflow, !(push && full), "token queue pushed while full")

endmodule

`default_nettype wire

// ----- design/asip_back.sv -----
// Back end: prefix and sign handling, digit accumulation, overflow clamp, result register.
// Depends on asip_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module asip_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [asip_pkg::BASE_W-1:0]    cfg_base,
    input  wire logic                           empty,
    input  wire asip_pkg::tok_t                 tok,
    output logic                                pop,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [63:0]                  m_value_high,
    output logic [63:0]                         m_value_low,
    output logic [asip_pkg::OFFSET_BITS-1:0]    m_end_offset,
    output logic                                m_saturated
);
    import asip_pkg::*;

    localparam int PROD_W = VALUE_BITS + BASE_W;
    localparam logic [VALUE_BITS-1:0] MAG_MAX = {1'b1, {(VALUE_BITS-1){1'b0}}};

    phase_t                 phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [BASE_W-1:0]      base_reg, base_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [OFFSET_BITS-1:0] cons_reg, cons_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0]    value_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   sat_reg;

    phase_t                 ph;
    logic                   take, signed_go, do_digit, emit, sat_now;
    logic [VALUE_BITS-1:0]  limit, emit_mag, emit_val;
    logic [PROD_W-1:0]      prod;

    assign pop = !empty && (!m_valid_reg || m_ready);

    always_comb begin
        ph        = phase_reg;
        neg_next  = neg_reg;
        base_next = base_reg;
        mag_next  = mag_reg;
        cons_next = cons_reg;
        take      = 1'b0;
        signed_go = 1'b0;
        do_digit  = 1'b0;
        emit      = 1'b0;
        sat_now   = 1'b0;
        emit_mag  = mag_reg;
        prod      = '0;

        if (tok.start) begin
            ph        = PH_LEAD;
            neg_next  = 1'b0;
            mag_next  = '0;
            cons_next = '0;
            base_next = (cfg_base >= MIN_BASE && cfg_base <= MAX_BASE) ? cfg_base : '0;
        end

        unique case (ph)
            PH_DONE: begin
            end
            PH_LEAD: begin
                if (tok.cls == CL_SPACE) begin
                    take = 1'b1;
                end else if (tok.cls == CL_PLUS || tok.cls == CL_MINUS) begin
                    neg_next = (tok.cls == CL_MINUS);
                    take     = 1'b1;
                    ph       = PH_SIGNED;
                end else begin
                    signed_go = 1'b1;
                end
            end
            PH_SIGNED: signed_go = 1'b1;
            PH_ZERO: begin
                if (base_next == '0) begin
                    if (tok.cls == CL_X || tok.cls == CL_B) begin
                        base_next = (tok.cls == CL_X) ? BASE_W'(16) : BASE_W'(2);
                        take      = 1'b1;
                        ph        = PH_DIGITS;
                    end else begin
                        base_next = BASE_W'(8);
                        do_digit  = 1'b1;
                    end
                end else if ((base_next == BASE_W'(2) && tok.cls == CL_B) ||
                             (base_next == BASE_W'(16) && tok.cls == CL_X)) begin
                    take = 1'b1;
                    ph   = PH_DIGITS;
                end else begin
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS: do_digit = 1'b1;
            default: begin
            end
        endcase

        if (signed_go) begin
            if (tok.cls == CL_ZERO) begin
                take = 1'b1;
                ph   = PH_ZERO;
            end else begin
                if (base_next == '0) begin
                    base_next = BASE_W'(10);
                end
                do_digit = 1'b1;
            end
        end

        limit = {1'b0, {(VALUE_BITS-1){1'b1}}} + VALUE_BITS'(neg_next);

        if (do_digit) begin
            ph   = PH_DIGITS;
            prod = PROD_W'(mag_next) * PROD_W'(base_next) + PROD_W'(tok.digit);
            if (tok.digit >= DIGIT_W'(base_next)) begin
                emit     = 1'b1;
                emit_mag = mag_next;
            end else if (prod > PROD_W'(limit)) begin
                emit     = 1'b1;
                sat_now  = 1'b1;
                emit_mag = limit;
            end else begin
                mag_next = prod[VALUE_BITS-1:0];
                take     = 1'b1;
            end
        end

        if (emit) begin
            ph = PH_DONE;
        end
        emit_val = neg_next ? (~emit_mag + VALUE_BITS'(1)) : emit_mag;

        if (take && cons_next != {OFFSET_BITS{1'b1}}) begin
            cons_next = cons_next + OFFSET_BITS'(1);
        end

        phase_next = ph;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop && emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DONE;
            neg_reg     <= 1'b0;
            base_reg    <= '0;
            mag_reg     <= '0;
            cons_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                mag_reg   <= mag_next;
                cons_reg  <= cons_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            value_reg  <= OUT_BITS'(signed'(emit_val));
            offset_reg <= cons_next;
            sat_reg    <= sat_now;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value_high = value_reg[OUT_BITS-1:OUT_BITS-64];
    assign m_value_low  = value_reg[63:0];
    assign m_end_offset = offset_reg;
    assign m_saturated  = sat_reg;

    `ASSERT_ALWAYS(a_mag_bound, mag_reg <= MAG_MAX, "magnitude beyond negative limit")
    `ASSERT_NEXT(a_sat_done, pop && sat_now, phase_reg == PH_DONE, "no stop after clamp")

endmodule

`default_nettype wire
